FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, dropped while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("transaction check failed");

// Concurrent check that also runs through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("reset check failed");

`endif

FILE: hdl/bzev_pkg.sv
// Shared constants and types for the cubic Bezier point evaluator.
package bzev_pkg;

  localparam int COORD_BITS      = 10;
  localparam int PARAM_FRAC_BITS = 10;
  localparam int CONTROL_POINTS  = 4;

  // One interpolation level per control point beyond the first.
  localparam int LEVELS  = CONTROL_POINTS - 1;
  localparam int PARAM_W = PARAM_FRAC_BITS + 1;
  // Widest exact value entering a cell, and the exact value leaving it.
  localparam int ACC_W   = COORD_BITS + (LEVELS - 1) * PARAM_FRAC_BITS;
  localparam int SUM_W   = ACC_W + PARAM_FRAC_BITS;
  localparam int PROD_W  = ACC_W + PARAM_W;
  // Input register plus one register per level.
  localparam int LATENCY = LEVELS + 1;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

  // Register file: four control points, x and y each.
  localparam int POINT_REGS  = 4;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_index_t;

endpackage

FILE: hdl/bzev_cell.sv
// One interpolation cell: value = (1 - t) * left + t * right, kept exact.
module bzev_cell (
  input  logic                          clk,
  input  logic [bzev_pkg::ACC_W-1:0]    left,
  input  logic [bzev_pkg::ACC_W-1:0]    right,
  input  logic [bzev_pkg::PARAM_W-1:0]  t,
  output logic [bzev_pkg::SUM_W-1:0]    value
);

  localparam int PROD_W = bzev_pkg::PROD_W;
  localparam int SUM_W  = bzev_pkg::SUM_W;

  logic [bzev_pkg::PARAM_W-1:0] u;
  logic [PROD_W-1:0]            sum;

  always_comb begin
    u   = bzev_pkg::PARAM_ONE - t;
    // convex weights, so the sum never leaves SUM_W bits
    sum = PROD_W'(left) * PROD_W'(u) + PROD_W'(right) * PROD_W'(t);
  end

  always_ff @(posedge clk) begin
    value <= sum[SUM_W-1:0];
  end

endmodule

FILE: hdl/cubic_bezier_point_evaluator_core.sv
// Top level of the cubic Bezier point evaluator (de Casteljau pipeline).
//
// Evaluates one point of a cubic Bezier curve per clock. Load the four
// control points through the write port (cfg_write, cfg_index 0..7 in the
// order p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, cfg_data) while no
// transaction is in flight. A transaction is accepted on every edge where
// start is high; busy stays low, so a new curve parameter may be issued every
// cycle. curve_param is t with 10 fraction bits (1024 = 1.0); values above
// 1024 clamp to 1.0. Each result appears on pixel_x / pixel_y for exactly one
// cycle with done high. The parameter register loads at the accepting edge,
// then each interpolation level adds one register. Results come out in
// issue order. The receiver cannot stall the block and must take every
// strobe. Results are the floor of the exact curve point; no intermediate
// rounding takes place.
module cubic_bezier_point_evaluator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bzev_pkg::PARAM_W-1:0]        curve_param,
  input  logic                                cfg_write,
  input  logic [bzev_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bzev_pkg::COORD_BITS-1:0]     cfg_data,
  output logic                                done,
  output logic [bzev_pkg::COORD_BITS-1:0]     pixel_x,
  output logic [bzev_pkg::COORD_BITS-1:0]     pixel_y
);

  localparam int LEVELS     = bzev_pkg::LEVELS;
  localparam int ACC_W      = bzev_pkg::ACC_W;
  localparam int SUM_W      = bzev_pkg::SUM_W;
  localparam int COORD_BITS = bzev_pkg::COORD_BITS;

  // Control point registers.
  logic [COORD_BITS-1:0] p_x [bzev_pkg::POINT_REGS];
  logic [COORD_BITS-1:0] p_y [bzev_pkg::POINT_REGS];

  // Pipeline control and the parameter that travels beside the data.
  logic [LEVELS:0]                valid_pipe;
  logic [bzev_pkg::PARAM_W-1:0]   t_pipe [LEVELS];
  logic [bzev_pkg::PARAM_W-1:0]   t_sat;
  logic                           accept;

  // Cell outputs, indexed by level and position in the row.
  logic [SUM_W-1:0] x_val [LEVELS][LEVELS];
  logic [SUM_W-1:0] y_val [LEVELS][LEVELS];

  // The pipeline never stalls, so every start is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp t to 1.0 before it enters the row.
  assign t_sat = (curve_param > bzev_pkg::PARAM_ONE) ? bzev_pkg::PARAM_ONE : curve_param;

  // Register file: writes land immediately, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bzev_pkg::POINT_REGS; i++) begin
        p_x[i] <= '0;
        p_y[i] <= '0;
      end
    end else if (cfg_write) begin
      case (bzev_pkg::reg_index_t'(cfg_index))
        bzev_pkg::REG_P0_X: p_x[0] <= cfg_data;
        bzev_pkg::REG_P0_Y: p_y[0] <= cfg_data;
        bzev_pkg::REG_P1_X: p_x[1] <= cfg_data;
        bzev_pkg::REG_P1_Y: p_y[1] <= cfg_data;
        bzev_pkg::REG_P2_X: p_x[2] <= cfg_data;
        bzev_pkg::REG_P2_Y: p_y[2] <= cfg_data;
        bzev_pkg::REG_P3_X: p_x[3] <= cfg_data;
        bzev_pkg::REG_P3_Y: p_y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the valid bits one level per cycle; reset drops anything in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[LEVELS-1:0], accept};
    end
  end

  // Hand t down the row in step with the data.
  always_ff @(posedge clk) begin
    t_pipe[0] <= t_sat;
    for (int k = 1; k < LEVELS; k++) begin
      t_pipe[k] <= t_pipe[k-1];
    end
  end

  // Triangle of cells: level lv holds LEVELS - lv cells per axis, each fed by
  // two neighbors of the level above (level 0 by two control points).
  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
    for (genvar c = 0; c < LEVELS - lv; c++) begin : g_cell
      if (lv == 0) begin : g_first
        bzev_cell u_cell_x (
          .clk   (clk),
          .left  (ACC_W'(p_x[c])),
          .right (ACC_W'(p_x[c+1])),
          .t     (t_pipe[lv]),
          .value (x_val[lv][c])
        );
        bzev_cell u_cell_y (
          .clk   (clk),
          .left  (ACC_W'(p_y[c])),
          .right (ACC_W'(p_y[c+1])),
          .t     (t_pipe[lv]),
          .value (y_val[lv][c])
        );
      end else begin : g_inner
        // values of the level above fit in ACC_W bits, drop the empty top
        bzev_cell u_cell_x (
          .clk   (clk),
          .left  (x_val[lv-1][c][ACC_W-1:0]),
          .right (x_val[lv-1][c+1][ACC_W-1:0]),
          .t     (t_pipe[lv]),
          .value (x_val[lv][c])
        );
        bzev_cell u_cell_y (
          .clk   (clk),
          .left  (y_val[lv-1][c][ACC_W-1:0]),
          .right (y_val[lv-1][c+1][ACC_W-1:0]),
          .t     (t_pipe[lv]),
          .value (y_val[lv][c])
        );
      end
    end
  end

  // Floor of the curve point: drop LEVELS * PARAM_FRAC_BITS fraction bits.
  assign pixel_x = x_val[LEVELS-1][0][SUM_W-1 -: COORD_BITS];
  assign pixel_y = y_val[LEVELS-1][0][SUM_W-1 -: COORD_BITS];
  assign done    = valid_pipe[LEVELS];

endmodule

FILE: hdl/bzev_checker.sv
// Port-level checks on the evaluator's fixed-latency result strobe.
`include "assert_macros.svh"

module bzev_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = bzev_pkg::LATENCY;

  `ASSERT_CLKD(a_start_gives_done, clk, rst, (start && !busy) |-> ##LAT done)
  `ASSERT_CLKD(a_done_has_start, clk, rst, done |-> $past(start && !busy, LAT))
  `ASSERT_CLKD(a_idle_gives_no_done, clk, rst, !(start && !busy) |-> ##LAT !done)
  `ASSERT_ALWAYS(a_reset_clears_done, clk, $past(rst) |-> !done)

endmodule

bind cubic_bezier_point_evaluator_core bzev_checker u_bzev_checker (.*);
